// ===== hw/rtl/periodic_timer_table_core_macros.svh =====
// Assertion macros used by the periodic timer table core.
`ifndef PERIODIC_TIMER_TABLE_CORE_MACROS_SVH
`define PERIODIC_TIMER_TABLE_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PTT_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define PTT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== hw/rtl/ptt_pkg.sv =====
// Types and constants of the periodic timer table.
`timescale 1ns / 1ps
package ptt_pkg;

   localparam int CMD_W             = 3;
   localparam int SLOT_W            = 3;
   localparam int TIME_W            = 32;
   localparam int NUM_SLOTS_DEFAULT = 8;

   localparam logic [CMD_W-1:0] CMD_ADD     = 3'd0;
   localparam logic [CMD_W-1:0] CMD_REMOVE  = 3'd1;
   localparam logic [CMD_W-1:0] CMD_DISABLE = 3'd2;
   localparam logic [CMD_W-1:0] CMD_ENABLE  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_TICK    = 3'd4;

   typedef struct packed {
      logic [CMD_W-1:0]  command;
      logic [SLOT_W-1:0] slot;
      logic [TIME_W-1:0] period;
      logic [TIME_W-1:0] now;
   } req_type;

   typedef struct packed {
      logic              fired;
      logic [SLOT_W-1:0] fired_slot;
      logic              add_ok;
      logic [SLOT_W-1:0] added_slot;
      logic [TIME_W-1:0] next_delay;
      logic              none_active;
      logic              last;
   } rsp_type;

   // Command token that walks the row of slot cells.
   typedef struct packed {
      logic              valid;
      logic [CMD_W-1:0]  command;
      logic [SLOT_W-1:0] slot;
      logic [TIME_W-1:0] period;
      logic [TIME_W-1:0] now;
      logic              add_ok;
      logic [SLOT_W-1:0] added_slot;
      logic              any;
      logic [TIME_W-1:0] nearest;
   } tok_type;

   typedef struct packed {
      logic              fire;
      logic [SLOT_W-1:0] slot;
   } fire_type;

endpackage

// ===== hw/rtl/ptt_req_if.sv =====
// Command channel of the periodic timer table.
`timescale 1ns / 1ps
interface ptt_req_if;
   logic             valid;
   logic             ready;
   ptt_pkg::req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/ptt_rsp_if.sv =====
// Result channel of the periodic timer table.
`timescale 1ns / 1ps
interface ptt_rsp_if;
   logic             valid;
   logic             ready;
   ptt_pkg::rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/ptt_cell.sv =====
// One timer slot cell: holds a slot's state and passes the command token on.
`timescale 1ns / 1ps
module ptt_cell #(
   parameter int INDEX = 0
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               step,
   input  ptt_pkg::tok_type   tok_in,
   output ptt_pkg::tok_type   tok_out,
   output ptt_pkg::fire_type  fire_out
);

   localparam int SW = ptt_pkg::SLOT_W;
   localparam logic [SW-1:0] MY_SLOT = SW'(INDEX % (1 << SW));
   localparam bit ADDRESSABLE = INDEX < (1 << SW);

   logic                        active_ff, active_in;
   logic [ptt_pkg::TIME_W-1:0]  period_ff, period_in;
   logic [ptt_pkg::TIME_W-1:0]  deadline_ff, deadline_in;
   ptt_pkg::tok_type            tok_ff, tok_in_next;
   logic                        is_slot;
   logic                        claim;
   logic                        fire;

   assign is_slot = ADDRESSABLE && (tok_in.slot == MY_SLOT);

   always_comb begin
      active_in   = active_ff;
      period_in   = period_ff;
      deadline_in = deadline_ff;
      claim       = 1'b0;
      fire        = 1'b0;
      case (tok_in.command)
         ptt_pkg::CMD_ADD: begin
            if (!tok_in.add_ok && !active_ff) begin
               active_in   = 1'b1;
               period_in   = tok_in.period;
               deadline_in = tok_in.now + tok_in.period;
               claim       = 1'b1;
            end
         end
         ptt_pkg::CMD_REMOVE: begin
            if (is_slot) begin
               active_in   = 1'b0;
               period_in   = '0;
               deadline_in = '0;
            end
         end
         ptt_pkg::CMD_DISABLE: begin
            if (is_slot) begin
               active_in = 1'b0;
            end
         end
         ptt_pkg::CMD_ENABLE: begin
            if (is_slot) begin
               active_in = 1'b1;
            end
         end
         ptt_pkg::CMD_TICK: begin
            if (active_ff && (deadline_ff <= tok_in.now)) begin
               fire        = 1'b1;
               deadline_in = tok_in.now + period_ff;
            end
         end
         default: begin
         end
      endcase

      tok_in_next = tok_in;
      if (claim) begin
         tok_in_next.add_ok     = 1'b1;
         tok_in_next.added_slot = MY_SLOT;
      end
      if (active_in && (!tok_in.any || (deadline_in < tok_in.nearest))) begin
         tok_in_next.any     = 1'b1;
         tok_in_next.nearest = deadline_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff   <= 1'b0;
         period_ff   <= '0;
         deadline_ff <= '0;
         tok_ff      <= '0;
      end else if (step) begin
         if (tok_in.valid) begin
            active_ff   <= active_in;
            period_ff   <= period_in;
            deadline_ff <= deadline_in;
         end
         tok_ff <= tok_in_next;
      end
   end

   assign tok_out       = tok_ff;
   assign fire_out.fire = tok_in.valid && fire;
   assign fire_out.slot = MY_SLOT;

endmodule

// ===== hw/rtl/periodic_timer_table_core.sv =====
// The status result of a command is registered once its token has passed every slot cell.
// A new command is accepted only after the previous token leaves the row; the token visits one slot
// cell per cycle and fired results leave on the way without holding the token up.
// A stalled result holds the token in place until the result is taken.
// Reset: synchronous, active high; clears all slots to inactive, period 0, deadline 0.
`timescale 1ns / 1ps
`include "periodic_timer_table_core_macros.svh"
module periodic_timer_table_core #(
   parameter int NUM_SLOTS = ptt_pkg::NUM_SLOTS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   ptt_req_if.sink    req_if,
   ptt_rsp_if.source  rsp_if
);

   localparam int SW = ptt_pkg::SLOT_W;

   ptt_pkg::tok_type   tok [NUM_SLOTS+1];
   ptt_pkg::fire_type  fire_v [NUM_SLOTS];
   ptt_pkg::tok_type   head_ff, head_in;
   ptt_pkg::tok_type   tail;
   ptt_pkg::rsp_type   rsp_data_ff, rsp_data_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               busy_ff, busy_in;
   logic               step;
   logic               accept;
   logic               fire_any;
   logic [SW-1:0]      fire_slot;

   assign step   = !rsp_valid_ff || rsp_if.ready;
   assign accept = req_if.valid && !busy_ff;
   assign tail   = tok[NUM_SLOTS];
   assign tok[0] = head_ff;

   genvar k;
   generate
      for (k = 0; k < NUM_SLOTS; k++) begin : g_cell
         ptt_cell #(
            .INDEX (k)
         ) u_cell (
            .clock    (clock),
            .reset    (reset),
            .step     (step),
            .tok_in   (tok[k]),
            .tok_out  (tok[k+1]),
            .fire_out (fire_v[k])
         );
      end
   endgenerate

   always_comb begin
      fire_any  = 1'b0;
      fire_slot = '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         if (fire_v[i].fire) begin
            fire_any  = 1'b1;
            fire_slot = fire_slot | fire_v[i].slot;
         end
      end
   end

   always_comb begin
      head_in = head_ff;
      if (accept) begin
         head_in.valid      = 1'b1;
         head_in.command    = req_if.payload.command;
         head_in.slot       = req_if.payload.slot;
         head_in.period     = req_if.payload.period;
         head_in.now        = req_if.payload.now;
         head_in.add_ok     = 1'b0;
         head_in.added_slot = '0;
         head_in.any        = 1'b0;
         head_in.nearest    = '0;
      end else if (step) begin
         head_in.valid = 1'b0;
      end

      busy_in = busy_ff;
      if (accept) begin
         busy_in = 1'b1;
      end else if (step && tail.valid) begin
         busy_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (step) begin
         rsp_valid_in = fire_any || tail.valid;
         rsp_data_in  = '0;
         if (fire_any) begin
            rsp_data_in.fired      = 1'b1;
            rsp_data_in.fired_slot = fire_slot;
         end else begin
            rsp_data_in.add_ok      = tail.add_ok;
            rsp_data_in.added_slot  = tail.added_slot;
            rsp_data_in.none_active = !tail.any;
            rsp_data_in.last        = 1'b1;
            if (tail.any && (tail.nearest > tail.now)) begin
               rsp_data_in.next_delay = tail.nearest - tail.now;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rsp_data_ff  <= '0;
      end else begin
         head_ff      <= head_in;
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_data_ff  <= rsp_data_in;
      end
   end

   assign req_if.ready   = !busy_ff;
   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.payload = rsp_data_ff;

   `PTT_ASSERT_NOW(a_fire_not_with_status, clock, reset, fire_any, !tail.valid)
   `PTT_ASSERT_NOW(a_accept_into_empty_row, clock, reset, accept, !head_ff.valid && !tail.valid)
   `PTT_ASSERT_NEXT(a_status_frees_input, clock, reset, step && tail.valid, !busy_ff)
   `PTT_ASSERT_NEXT(a_status_is_last, clock, reset, step && tail.valid,
                    rsp_valid_ff && rsp_data_ff.last)

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for periodic_timer_table_core: directed, backpressure and random traffic.
`timescale 1ns / 1ps
module tb;

   localparam int NUM_SLOTS    = 8;
   localparam int DRAIN_CYCLES = 3 * (NUM_SLOTS + 2);
   localparam int CW           = ptt_pkg::CMD_W;
   localparam int SW           = ptt_pkg::SLOT_W;
   localparam int TW           = ptt_pkg::TIME_W;

   logic clock;
   logic reset;

   ptt_req_if req_ch ();
   ptt_rsp_if rsp_ch ();

   periodic_timer_table_core #(
      .NUM_SLOTS (NUM_SLOTS)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   logic              timer_active   [NUM_SLOTS];
   logic [TW-1:0]     timer_period   [NUM_SLOTS];
   logic [TW-1:0]     timer_deadline [NUM_SLOTS];
   ptt_pkg::rsp_type  pending_results [$];
   ptt_pkg::rsp_type  want_rsp;

   int fail_count    = 0;
   int n_commands    = 0;
   int n_checked     = 0;
   int n_expired     = 0;
   int n_full_adds   = 0;
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int rsp_hold_left = 0;
   logic [TW-1:0] cur_now;

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic ptt_pkg::req_type make_cmd(input logic [CW-1:0] command,
                                                 input logic [SW-1:0] slot,
                                                 input logic [TW-1:0] period,
                                                 input logic [TW-1:0] now);
      ptt_pkg::req_type r;
      r.command = command;
      r.slot    = slot;
      r.period  = period;
      r.now     = now;
      return r;
   endfunction

   function automatic void predict_timer_results(input ptt_pkg::req_type r);
      ptt_pkg::rsp_type  status;
      ptt_pkg::rsp_type  expiry;
      logic              found;
      logic              any;
      logic [TW-1:0]     nearest;
      found   = 1'b0;
      any     = 1'b0;
      nearest = '0;
      status  = '0;
      case (r.command)
         ptt_pkg::CMD_ADD: begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
               if (!found && !timer_active[i]) begin
                  found             = 1'b1;
                  timer_active[i]   = 1'b1;
                  timer_period[i]   = r.period;
                  timer_deadline[i] = r.now + r.period;
                  status.add_ok     = 1'b1;
                  status.added_slot = SW'(i);
               end
            end
            if (!found) n_full_adds++;
         end
         ptt_pkg::CMD_REMOVE: begin
            if (int'(r.slot) < NUM_SLOTS) begin
               timer_active[r.slot]   = 1'b0;
               timer_period[r.slot]   = '0;
               timer_deadline[r.slot] = '0;
            end
         end
         ptt_pkg::CMD_DISABLE: begin
            if (int'(r.slot) < NUM_SLOTS) timer_active[r.slot] = 1'b0;
         end
         ptt_pkg::CMD_ENABLE: begin
            if (int'(r.slot) < NUM_SLOTS) timer_active[r.slot] = 1'b1;
         end
         ptt_pkg::CMD_TICK: begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
               if (timer_active[i] && timer_deadline[i] <= r.now) begin
                  expiry            = '0;
                  expiry.fired      = 1'b1;
                  expiry.fired_slot = SW'(i);
                  pending_results.push_back(expiry);
                  n_expired++;
                  timer_deadline[i] = r.now + timer_period[i];
               end
            end
         end
         default: begin
         end
      endcase
      for (int i = 0; i < NUM_SLOTS; i++) begin
         if (timer_active[i] && (!any || timer_deadline[i] < nearest)) begin
            nearest = timer_deadline[i];
            any     = 1'b1;
         end
      end
      status.next_delay  = (any && nearest > r.now) ? nearest - r.now : '0;
      status.none_active = !any;
      status.last        = 1'b1;
      pending_results.push_back(status);
   endfunction

   task automatic compare_field(input string name, input logic [TW-1:0] want,
                                input logic [TW-1:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         n_checked++;
         if (pending_results.size() == 0) begin
            $error("unexpected result transaction %p", rsp_ch.payload);
            fail_count++;
         end else begin
            want_rsp = pending_results.pop_front();
            compare_field("fired", TW'(want_rsp.fired), TW'(rsp_ch.payload.fired));
            compare_field("fired_slot", TW'(want_rsp.fired_slot),
                          TW'(rsp_ch.payload.fired_slot));
            compare_field("add_ok", TW'(want_rsp.add_ok), TW'(rsp_ch.payload.add_ok));
            compare_field("added_slot", TW'(want_rsp.added_slot),
                          TW'(rsp_ch.payload.added_slot));
            compare_field("next_delay", want_rsp.next_delay, rsp_ch.payload.next_delay);
            compare_field("none_active", TW'(want_rsp.none_active),
                          TW'(rsp_ch.payload.none_active));
            compare_field("last", TW'(want_rsp.last), TW'(rsp_ch.payload.last));
         end
      end
   end

   // Result side: hold off while a hold count is pending, else stall at random.
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_left > 0) begin
            rsp_ch.ready <= 1'b0;
            rsp_hold_left--;
         end else begin
            rsp_ch.ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
         end
      end
   end

   task automatic send_command(input ptt_pkg::req_type r);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.payload <= r;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      predict_timer_results(r);
      n_commands++;
      @(negedge clock);
   endtask

   task automatic wait_for_drain();
      req_ch.valid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic test_empty_table();
      send_command(make_cmd(ptt_pkg::CMD_TICK, '0, '0, '0));
      send_command(make_cmd(ptt_pkg::CMD_REMOVE, '1, '1, '1));
      wait_for_drain();
   endtask

   task automatic test_fill_table();
      logic [TW-1:0] periods [9];
      periods = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd5, 32'd1000, 32'h8000_0000,
                  32'd3, 32'd7, 32'd9};
      foreach (periods[i]) begin
         send_command(make_cmd(ptt_pkg::CMD_ADD, SW'(i), periods[i], 32'd100));
      end
      wait_for_drain();
   endtask

   task automatic test_expiry();
      send_command(make_cmd(ptt_pkg::CMD_TICK, '0, '0, 32'd100));
      send_command(make_cmd(ptt_pkg::CMD_TICK, '0, '0, 32'd105));
      send_command(make_cmd(ptt_pkg::CMD_TICK, '0, '0, 32'hFFFF_FFFF));
      wait_for_drain();
   endtask

   task automatic test_slot_controls();
      send_command(make_cmd(ptt_pkg::CMD_DISABLE, 3'd2, '0, 32'd10));
      send_command(make_cmd(ptt_pkg::CMD_ENABLE, 3'd2, '0, 32'd10));
      send_command(make_cmd(ptt_pkg::CMD_REMOVE, 3'd3, '1, 32'd10));
      send_command(make_cmd(ptt_pkg::CMD_ENABLE, 3'd3, '0, 32'd10));
      send_command(make_cmd(ptt_pkg::CMD_DISABLE, 3'd7, '0, 32'd10));
      send_command(make_cmd(ptt_pkg::CMD_TICK, '0, '0, '0));
      wait_for_drain();
   endtask

   task automatic test_unknown_commands();
      for (int c = int'(ptt_pkg::CMD_TICK) + 1; c < (1 << CW); c++) begin
         send_command(make_cmd(CW'(c), SW'($urandom), $urandom, $urandom));
      end
      wait_for_drain();
   endtask

   task automatic test_backpressure();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      rsp_hold_left = 400;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         send_command(make_cmd(ptt_pkg::CMD_ENABLE, SW'(i), '0, '0));
      end
      repeat (6) send_command(make_cmd(ptt_pkg::CMD_TICK, '0, '0, 32'hFFFF_FFFF));
      wait_for_drain();
   endtask

   task automatic test_random_traffic(input int count, input int idle_pct,
                                      input int stall_pct);
      ptt_pkg::req_type r;
      int               pick;
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      for (int k = 0; k < count; k++) begin
         pick = $urandom_range(0, 99);
         r    = make_cmd(ptt_pkg::CMD_TICK, SW'($urandom), $urandom, '0);
         if (pick < 45) begin
            cur_now += $urandom_range(0, 20);
         end else if (pick < 60) begin
            r.command = ptt_pkg::CMD_ADD;
            r.period  = $urandom_range(0, 40);
         end else if (pick < 66) begin
            r.command = ptt_pkg::CMD_ADD;
         end else if (pick < 78) begin
            r.command = ptt_pkg::CMD_REMOVE;
         end else if (pick < 85) begin
            r.command = ptt_pkg::CMD_DISABLE;
         end else if (pick < 92) begin
            r.command = ptt_pkg::CMD_ENABLE;
         end else if (pick < 96) begin
            r.command = CW'($urandom_range(int'(ptt_pkg::CMD_TICK) + 1, (1 << CW) - 1));
         end else if ($urandom_range(0, 1) == 1) begin
            cur_now = $urandom;
         end else begin
            cur_now = '1 - TW'($urandom_range(0, 15));
         end
         r.now = cur_now;
         send_command(r);
      end
      wait_for_drain();
   endtask

   initial begin
      reset          = 1'b1;
      req_ch.valid   = 1'b0;
      req_ch.payload = '0;
      cur_now        = '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         timer_active[i]   = 1'b0;
         timer_period[i]   = '0;
         timer_deadline[i] = '0;
      end
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_empty_table();
      test_fill_table();
      test_expiry();
      test_slot_controls();
      test_unknown_commands();
      test_backpressure();
      test_random_traffic(90, 0, 0);
      test_random_traffic(90, 55, 0);
      test_random_traffic(90, 0, 55);
      test_random_traffic(90, 24, 24);

      $display("Ran %0d commands and checked %0d result transactions", n_commands, n_checked);
      $display("  including %0d expirations and %0d adds on a full table",
               n_expired, n_full_adds);
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/ptt_pkg.sv
hw/rtl/ptt_req_if.sv
hw/rtl/ptt_rsp_if.sv
hw/rtl/ptt_cell.sv
hw/rtl/periodic_timer_table_core.sv
dv/tb.sv
